// File: design/pcm_voice_mixer_macros.svh
// Assertion macros for the mixer.
`ifndef PCM_VOICE_MIXER_MACROS_SVH
`define PCM_VOICE_MIXER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PVM_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define PVM_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define PVM_ASSERT_IMP(label, clk, rst, a, c)
`define PVM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: design/pvm_pkg.sv
package pvm_pkg;
   localparam int VOICES = 16;
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int MEM_DEPTH = 65536;
   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [2:0] REQ_TICK = 3'd0;
   localparam logic [2:0] REQ_LOAD = 3'd1;
   localparam logic [2:0] REQ_START = 3'd2;
   localparam logic [2:0] REQ_VOLUME = 3'd3;
   localparam logic [2:0] REQ_STOP = 3'd4;
   localparam logic [2:0] REQ_QUERY = 3'd5;
   localparam logic [15:0] FMT_PCM = 16'd3;
   localparam logic [16:0] MIN_SIZE = 17'd48;
   localparam logic [4:0] HDR_SKIP = 5'd24;
   localparam logic [31:0] OUT_RATE = 32'd11025;
   // ceil(2^46 / OUT_RATE): (rate << 16) / OUT_RATE is (rate * RATE_RECIP) >> 30
   localparam logic [32:0] RATE_RECIP = 33'd6382652534;

   typedef struct packed {
      logic [2:0] req_type;
      logic [3:0] voice;
      logic [15:0] mem_address;
      logic [7:0] mem_byte;
      logic [16:0] sound_size;
      logic [6:0] gain;
   } req_type_t_type;

   typedef struct packed {
      logic [7:0] mixed_sample;
      logic rejected;
      logic voice_playing;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HDR_ADDR, ST_HDR_WAIT, ST_DIV, ST_VREAD, ST_VCHECK,
      ST_SREAD, ST_SMIX, ST_DONE
   } state_type;
endpackage

// File: design/pcm_voice_mixer.sv
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_data (pvm_pkg::req_type_t_type)
// rsp     | out | rsp_valid/rsp_ready  | rsp_data (pvm_pkg::rsp_type)
// Load, stop, query, unknown and early refused start go straight to ST_DONE.
// Volume: ST_SREAD, ST_VCHECK, ST_DONE. Start: 8 header reads, 1 multiply, ST_DONE.
// Tick: ST_VREAD and ST_VCHECK per voice, ST_SMIX per mixed voice, then ST_DONE.
// Reset clears the state machine, voice active flags and rsp_valid; memories keep data.
// A held result on rsp stalls only the completion of the following request.
`include "pcm_voice_mixer_macros.svh"
module pcm_voice_mixer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pvm_pkg::req_type_t_type       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pvm_pkg::rsp_type              rsp_data
);
   localparam int VW = pvm_pkg::VW;
   localparam int AW = pvm_pkg::AW;

   logic [7:0] smem [pvm_pkg::MEM_DEPTH];
   logic [89:0] vmem [pvm_pkg::VOICES];

   pvm_pkg::state_type st_ff, st_in;
   pvm_pkg::req_type_t_type rq_ff, rq_in;
   logic [pvm_pkg::VOICES-1:0] act_ff, act_in;
   logic [VW:0] vi_ff, vi_in;
   logic [3:0] hc_ff, hc_in;
   logic [63:0] hdr_ff, hdr_in;
   logic signed [11:0] sum_ff, sum_in;
   logic [7:0] srd_ff;
   logic [89:0] vrd_ff, ent_ff, ent_in;
   logic rsv_ff, rsv_in;
   pvm_pkg::rsp_type res_ff, res_in;
   pvm_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0] sa;
   logic sw;
   logic [VW-1:0] va;
   logic vw;
   logic [89:0] vwd;
   logic div_go, div_done;
   logic [18:0] quo;
   logic [31:0] hlen;
   logic signed [8:0] sm;
   logic signed [16:0] prod;
   logic signed [11:0] sumc;
   logic busy;
   logic [VW:0] vi_inc;

   pvm_divider u_div (
      .clock(clock), .reset(reset), .start(div_go), .rate(hdr_in[31:16]),
      .done(div_done), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (sw) smem[sa] <= rq_ff.mem_byte;
      srd_ff <= smem[sa];
   end
   always_ff @(posedge clock) begin
      if (vw) vmem[va] <= vwd;
      vrd_ff <= vmem[va];
   end

   assign hlen = hdr_ff[63:32];
   assign sm = $signed({1'b0, srd_ff}) - 9'sd128;
   assign prod = sm * $signed({1'b0, ent_ff[6:0]});
   assign busy = st_ff != pvm_pkg::ST_IDLE;
   assign req_ready = !busy;
   assign vi_inc = vi_ff + (VW+1)'(1);

   // entry: [89:58] pos, [57:39] step, [38:23] len, [22:7] base, [6:0] gain
   always_comb begin
      st_in = st_ff; rq_in = rq_ff; act_in = act_ff; vi_in = vi_ff; hc_in = hc_ff;
      hdr_in = hdr_ff; sum_in = sum_ff; ent_in = ent_ff; res_in = res_ff;
      rsp_in = rsp_ff; rsv_in = rsv_ff;
      sa = rq_ff.mem_address[AW-1:0]; sw = 1'b0;
      va = vi_ff[VW-1:0]; vw = 1'b0; vwd = ent_ff; div_go = 1'b0;
      sumc = sum_ff;
      if (rsv_ff && rsp_ready) rsv_in = 1'b0;
      case (st_ff)
         pvm_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               rq_in = req_data;
               res_in = '{mixed_sample: 8'd128, rejected: 1'b0, voice_playing: 1'b0};
               vi_in = '0; hc_in = '0; sum_in = '0;
               st_in = pvm_pkg::ST_DONE;
               case (req_data.req_type)
                  pvm_pkg::REQ_TICK: st_in = pvm_pkg::ST_VREAD;
                  pvm_pkg::REQ_LOAD: ;
                  pvm_pkg::REQ_START: begin
                     if (32'(req_data.voice) >= pvm_pkg::VOICES ||
                         req_data.sound_size < pvm_pkg::MIN_SIZE)
                        res_in.rejected = 1'b1;
                     else st_in = pvm_pkg::ST_HDR_ADDR;
                  end
                  pvm_pkg::REQ_VOLUME, pvm_pkg::REQ_STOP: begin
                     if (32'(req_data.voice) < pvm_pkg::VOICES) begin
                        vi_in = (VW+1)'(req_data.voice);
                        st_in = pvm_pkg::ST_VCHECK;
                        if (req_data.req_type == pvm_pkg::REQ_STOP) begin
                           act_in[req_data.voice[VW-1:0]] = 1'b0;
                           st_in = pvm_pkg::ST_DONE;
                        end
                     end
                  end
                  pvm_pkg::REQ_QUERY:
                     res_in.voice_playing = 32'(req_data.voice) < pvm_pkg::VOICES &&
                        act_ff[req_data.voice[VW-1:0]];
                  default: ;
               endcase
               if (req_data.req_type == pvm_pkg::REQ_VOLUME) st_in = (32'(req_data.voice) <
                  pvm_pkg::VOICES) ? pvm_pkg::ST_SREAD : pvm_pkg::ST_DONE;
            end
         end
         pvm_pkg::ST_HDR_ADDR: begin
            sa = AW'(rq_ff.mem_address + 16'(hc_ff));
            st_in = pvm_pkg::ST_HDR_WAIT;
         end
         pvm_pkg::ST_HDR_WAIT: begin
            hdr_in = {srd_ff, hdr_ff[63:8]};
            hc_in = hc_ff + 4'd1;
            st_in = (hc_ff == 4'd7) ? pvm_pkg::ST_DIV : pvm_pkg::ST_HDR_ADDR;
            if (hc_ff == 4'd7) begin
               if ({hdr_in[15:0]} != pvm_pkg::FMT_PCM || hdr_in[31:16] == 16'd0 ||
                   hdr_in[63:32] > 32'(rq_ff.sound_size - 17'd8) ||
                   hdr_in[63:32] <= 32'd32) begin
                  res_in.rejected = 1'b1;
                  st_in = pvm_pkg::ST_DONE;
               end else div_go = 1'b1;
            end
         end
         pvm_pkg::ST_DIV: begin
            if (div_done) begin
               va = rq_ff.voice[VW-1:0];
               vw = 1'b1;
               vwd = {32'd0, quo, 16'(hlen - 32'd32), rq_ff.mem_address, rq_ff.gain};
               act_in[rq_ff.voice[VW-1:0]] = 1'b1;
               st_in = pvm_pkg::ST_DONE;
            end
         end
         pvm_pkg::ST_SREAD: st_in = pvm_pkg::ST_VCHECK;
         pvm_pkg::ST_VREAD: begin
            if (32'(vi_ff) >= pvm_pkg::VOICES) begin
               sumc = (sum_ff < -12'sd128) ? -12'sd128 :
                      (sum_ff > 12'sd127) ? 12'sd127 : sum_ff;
               res_in.mixed_sample = 8'(sumc + 12'sd128);
               st_in = pvm_pkg::ST_DONE;
            end else st_in = pvm_pkg::ST_VCHECK;
         end
         pvm_pkg::ST_VCHECK: begin
            ent_in = vrd_ff;
            if (rq_ff.req_type == pvm_pkg::REQ_VOLUME) begin
               vw = 1'b1;
               vwd = {vrd_ff[89:7], rq_ff.gain};
               st_in = pvm_pkg::ST_DONE;
            end else if (!act_ff[vi_ff[VW-1:0]]) begin
               vi_in = vi_inc;
               st_in = pvm_pkg::ST_VREAD;
            end else if (vrd_ff[89:74] >= vrd_ff[38:23]) begin
               act_in[vi_ff[VW-1:0]] = 1'b0;
               vi_in = vi_inc;
               st_in = pvm_pkg::ST_VREAD;
            end else begin
               sa = AW'(vrd_ff[22:7] + 16'(pvm_pkg::HDR_SKIP) + vrd_ff[89:74]);
               st_in = pvm_pkg::ST_SMIX;
            end
         end
         pvm_pkg::ST_SMIX: begin
            sum_in = sum_ff + 12'(prod >>> 7);
            vw = 1'b1;
            vwd = {ent_ff[89:58] + 32'(ent_ff[57:39]), ent_ff[57:0]};
            vi_in = vi_inc;
            st_in = pvm_pkg::ST_VREAD;
         end
         pvm_pkg::ST_DONE: begin
            if (!rsv_ff || rsp_ready) begin
               if (rq_ff.req_type == pvm_pkg::REQ_LOAD) sw = 1'b1;
               rsp_in = res_ff;
               rsv_in = 1'b1;
               st_in = pvm_pkg::ST_IDLE;
            end
         end
         default: st_in = pvm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in; hdr_ff <= hdr_in; ent_ff <= ent_in; res_ff <= res_in;
      rsp_ff <= rsp_in; sum_ff <= sum_in; hc_ff <= hc_in; vi_ff <= vi_in;
      if (reset) begin
         st_ff <= pvm_pkg::ST_IDLE;
         act_ff <= '0;
         rsv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         act_ff <= act_in;
         rsv_ff <= rsv_in;
      end
   end

   assign rsp_valid = rsv_ff;
   assign rsp_data = rsp_ff;

   `PVM_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, st_ff == pvm_pkg::ST_IDLE)
   `PVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PVM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
endmodule

// File: design/pvm_divider.sv
module pvm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] rate,
   output logic        done,
   output logic [18:0] quotient
);
   logic [48:0] prod_ff, prod_in;
   logic        done_ff;

   assign prod_in = 49'(rate) * 49'(pvm_pkg::RATE_RECIP);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   assign done = done_ff;
   assign quotient = (prod_ff[48:30] == 19'd0) ? 19'd1 : prod_ff[48:30];
endmodule
